>>> hdl/frfp_pkg.sv
// ----------------------------------------------------------------------------
// frfp_pkg
// Shared constants and payload types of the range and flow frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package frfp_pkg;

  // default sizes
  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  // frame constants
  localparam logic [7:0] HEAD_BYTE = 8'hEF;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOW = CFG_IDX_W'(1);

  localparam logic [31:0] RESET_MAX_DIST = 32'd12000000;
  localparam logic [15:0] RESET_MAX_FLOW = 16'd700;

  // decoded frame fields handed from the front to the back
  typedef struct packed {
    logic [31:0] distance_mm;
    logic [15:0] flow_x;
    logic [15:0] flow_y;
    logic [7:0]  quality;
    logic [31:0] time_ms;
  } frame_t;

  // validated result
  typedef struct packed {
    logic [31:0]        distance_mm;
    logic signed [15:0] flow_roll;
    logic signed [15:0] flow_pitch;
    logic [7:0]         flow_grade;
    logic [31:0]        sensor_time_ms;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/flow_range_frame_parser.sv
// A checked frame is registered in the frame queue, then in the result queue.
// Throughput: one byte per cycle; in_full rises only while the frame queue
// between parser and checker is full, i.e. while results back up at the output.
// Reset: synchronous, active low; parser back to head hunt, both queues empty,
// limits back to 12000000 mm and 700.
// ----------------------------------------------------------------------------
// flow_range_frame_parser
// Serial range and optical flow frame parser with additive checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module flow_range_frame_parser
  import frfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic [7:0]            in_rx_byte,
  output logic                       in_full,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic [31:0]                out_distance_mm,
  output logic signed [15:0]         out_flow_roll,
  output logic signed [15:0]         out_flow_pitch,
  output logic [7:0]                 out_flow_grade,
  output logic [31:0]                out_sensor_time_ms,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic    fq_push, fq_full, fq_pop, fq_empty;
  frame_t  fq_wdata, fq_rdata;
  logic    rq_push, rq_full;
  result_t rq_wdata, rq_rdata;

  // byte parser
  frfp_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_rx_byte(in_rx_byte),
    .in_full   (in_full),
    .q_push    (fq_push),
    .q_data    (fq_wdata),
    .q_full    (fq_full)
  );

  // checked frames waiting for validation
  frfp_fifo #(
    .WIDTH($bits(frame_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_frame_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fq_push),
    .wdata(fq_wdata),
    .full (fq_full),
    .pop  (fq_pop),
    .rdata(fq_rdata),
    .empty(fq_empty)
  );

  // limit check
  frfp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_data   (fq_rdata),
    .q_empty  (fq_empty),
    .q_pop    (fq_pop),
    .r_push   (rq_push),
    .r_data   (rq_wdata),
    .r_full   (rq_full)
  );

  // result queue
  frfp_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_result_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (rq_push),
    .wdata(rq_wdata),
    .full (rq_full),
    .pop  (out_pop),
    .rdata(rq_rdata),
    .empty(out_empty)
  );

  assign out_distance_mm    = rq_rdata.distance_mm;
  assign out_flow_roll      = rq_rdata.flow_roll;
  assign out_flow_pitch     = rq_rdata.flow_pitch;
  assign out_flow_grade     = rq_rdata.flow_grade;
  assign out_sensor_time_ms = rq_rdata.sensor_time_ms;

endmodule

`default_nettype wire

>>> hdl/frfp_fifo.sv
// ----------------------------------------------------------------------------
// frfp_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module frfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> hdl/frfp_front.sv
// ----------------------------------------------------------------------------
// frfp_front
// Byte-serial frame parser: hunts the head, tracks the header, sums the
// checksum and captures the payload fields; queues frames whose sum matches.
// ----------------------------------------------------------------------------
`default_nettype none

module frfp_front
  import frfp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [7:0] in_rx_byte,
  output logic            in_full,
  output logic            q_push,
  output frame_t          q_data,
  input  wire logic       q_full
);

  typedef enum logic [7:0] {
    ST_HUNT = 8'b0000_0001,
    ST_DEV  = 8'b0000_0010,
    ST_SYS  = 8'b0000_0100,
    ST_MSG  = 8'b0000_1000,
    ST_SEQ  = 8'b0001_0000,
    ST_LEN  = 8'b0010_0000,
    ST_PAY  = 8'b0100_0000,
    ST_SUM  = 8'b1000_0000
  } phase_t;

  phase_t      state_r, state_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [6:0]  pos_inc;
  frame_t      frame_r, frame_nxt;
  logic        accept;
  logic [4:0]  sel32;
  logic [3:0]  sel16;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_data  = frame_r;
  assign pos_inc = pos_r + 7'd1;
  assign sel32   = {pos_r[1:0], 3'b000};
  assign sel16   = {pos_r[0], 3'b000};

  // parser next state
  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    q_push    = 1'b0;
    if (accept) begin
      unique case (state_r)
        ST_HUNT: begin
          if (in_rx_byte == HEAD_BYTE) begin
            frame_nxt = '0;
            sum_nxt   = HEAD_BYTE;
            pos_nxt   = '0;
            state_nxt = ST_DEV;
          end
        end
        ST_DEV: begin
          sum_nxt   = sum_r + in_rx_byte;
          state_nxt = ST_SYS;
        end
        ST_SYS: begin
          sum_nxt   = sum_r + in_rx_byte;
          state_nxt = ST_MSG;
        end
        ST_MSG: begin
          sum_nxt   = sum_r + in_rx_byte;
          state_nxt = ST_SEQ;
        end
        ST_SEQ: begin
          sum_nxt   = sum_r + in_rx_byte;
          state_nxt = ST_LEN;
        end
        ST_LEN: begin
          priority if (in_rx_byte == 8'd0) begin
            len_nxt   = '0;
            state_nxt = ST_SUM;
          end else if (in_rx_byte > 8'(MAX_PAYLOAD)) begin
            state_nxt = ST_HUNT;
          end else begin
            len_nxt   = in_rx_byte[6:0];
            sum_nxt   = sum_r + in_rx_byte;
            pos_nxt   = '0;
            state_nxt = ST_PAY;
          end
        end
        ST_PAY: begin
          // little-endian field capture, other positions only summed
          priority if (pos_r < 7'd4) begin
            frame_nxt.time_ms[sel32 +: 8] = in_rx_byte;
          end else if (pos_r < 7'd8) begin
            frame_nxt.distance_mm[sel32 +: 8] = in_rx_byte;
          end else if (pos_r == 7'd12 || pos_r == 7'd13) begin
            frame_nxt.flow_x[sel16 +: 8] = in_rx_byte;
          end else if (pos_r == 7'd14 || pos_r == 7'd15) begin
            frame_nxt.flow_y[sel16 +: 8] = in_rx_byte;
          end else if (pos_r == 7'd16) begin
            frame_nxt.quality = in_rx_byte;
          end
          sum_nxt = sum_r + in_rx_byte;
          if (pos_inc >= len_r) begin
            pos_nxt   = '0;
            state_nxt = ST_SUM;
          end else begin
            pos_nxt = pos_inc;
          end
        end
        ST_SUM: begin
          q_push    = (in_rx_byte == sum_r);
          state_nxt = ST_HUNT;
        end
        default: state_nxt = ST_HUNT;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      sum_r   <= '0;
      len_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // captured fields, cleared at each head byte
  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/frfp_back.sv
// ----------------------------------------------------------------------------
// frfp_back
// Plausibility check of checked frames against the configured limits and
// mapping of the sensor axes onto the result.
// ----------------------------------------------------------------------------
`default_nettype none

module frfp_back
  import frfp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire frame_t                q_data,
  input  wire logic                  q_empty,
  output logic                       q_pop,
  output logic                       r_push,
  output result_t                    r_data,
  input  wire logic                  r_full
);

  logic [31:0] max_dist_r, max_dist_nxt;
  logic [15:0] max_flow_r, max_flow_nxt;
  logic [16:0] mag_x, mag_y;
  logic        plausible;

  // limit registers
  always_comb begin
    max_dist_nxt = max_dist_r;
    max_flow_nxt = max_flow_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_DIST: max_dist_nxt = cfg_wdata[31:0];
        REG_MAX_FLOW: max_flow_nxt = cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dist_r <= RESET_MAX_DIST;
      max_flow_r <= RESET_MAX_FLOW;
    end else begin
      max_dist_r <= max_dist_nxt;
      max_flow_r <= max_flow_nxt;
    end
  end

  // flow magnitudes, -32768 gives 32768
  assign mag_x = q_data.flow_x[15] ? (17'h10000 - {1'b0, q_data.flow_x}) : {1'b0, q_data.flow_x};
  assign mag_y = q_data.flow_y[15] ? (17'h10000 - {1'b0, q_data.flow_y}) : {1'b0, q_data.flow_y};

  assign plausible = (q_data.distance_mm != 32'd0) &&
                     (q_data.distance_mm <= max_dist_r) &&
                     (mag_x <= {1'b0, max_flow_r}) &&
                     (mag_y <= {1'b0, max_flow_r});

  // drain one frame per cycle while the result queue is not full, rejected ones are dropped
  assign q_pop  = !q_empty && !r_full;
  assign r_push = q_pop && plausible;

  always_comb begin
    r_data.distance_mm    = q_data.distance_mm;
    r_data.flow_roll      = q_data.flow_y;
    r_data.flow_pitch     = q_data.flow_x;
    r_data.flow_grade     = q_data.quality;
    r_data.sensor_time_ms = q_data.time_ms;
  end

endmodule

`default_nettype wire

>>> hdl/frfp_checker.sv
// ----------------------------------------------------------------------------
// frfp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module frfp_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_full,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire logic [31:0]        out_distance_mm,
  input wire logic signed [15:0] out_flow_roll,
  input wire logic signed [15:0] out_flow_pitch,
  input wire logic [7:0]         out_flow_grade,
  input wire logic [31:0]        out_sensor_time_ms
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a zero distance is never reported
  a_nonzero_distance: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_distance_mm != 32'd0))
    else $error("result with zero distance");

  // waiting result holds until its transfer
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_distance_mm) && $stable(out_flow_roll) &&
       $stable(out_flow_pitch) && $stable(out_flow_grade) &&
       $stable(out_sensor_time_ms)))
    else $error("waiting result changed");

  // a back-pressured input can only come from a waiting result
  a_full_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !out_empty)
    else $error("input full with no result waiting");

endmodule

bind flow_range_frame_parser frfp_checker u_frfp_checker (.*);

`default_nettype wire
